/* hw/rtl/rme_pkg.sv */
// shared constants and types for the modular exponentiation block
// no dependencies; imported by the multiply sequencer and the top level
package rme_pkg;

   localparam int WORD_WIDTH_DEF  = 64;
   localparam int CSR_INDEX_WIDTH = 8;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_EXPONENT = 8'd0,
      CSR_MODULUS  = 8'd1
   } csr_index_type;

   // top level to multiply sequencer
   typedef struct packed {
      logic start;
      logic square;
   } mul_ctl_type;

   // multiply sequencer to top level
   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

endpackage

/* hw/rtl/rme_if.sv */
// valid/ready stream interfaces for the request and response channels
// depends on rme_pkg for the default word width
interface rme_req_if #(parameter int WORD_WIDTH = rme_pkg::WORD_WIDTH_DEF);
   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] message;

   modport source (output valid, output message, input ready);
   modport sink (input valid, input message, output ready);
endinterface

interface rme_rsp_if #(parameter int WORD_WIDTH = rme_pkg::WORD_WIDTH_DEF);
   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] result;
   logic                  out_of_range;

   modport source (output valid, output result, output out_of_range, input ready);
   modport sink (input valid, input result, input out_of_range, output ready);
endinterface

/* hw/rtl/rme_modadd.sv */
// shared modular adder: (a + b) mod m, valid when a + b < 2m
// depends on rme_pkg for the default word width
module rme_modadd #(
   parameter int WORD_WIDTH = rme_pkg::WORD_WIDTH_DEF
) (
   input  logic [WORD_WIDTH-1:0] a_i,
   input  logic [WORD_WIDTH-1:0] b_i,
   input  logic [WORD_WIDTH-1:0] modulus_i,
   output logic [WORD_WIDTH-1:0] sum_o
);
   logic [WORD_WIDTH:0]   sum_raw;
   logic [WORD_WIDTH+1:0] sum_sub;

   always_comb begin
      sum_raw = {1'b0, a_i} + {1'b0, b_i};
      sum_sub = {1'b0, sum_raw} - {2'b00, modulus_i};
      // borrow out means the raw sum is already below the modulus
      sum_o   = sum_sub[WORD_WIDTH+1] ? sum_raw[WORD_WIDTH-1:0] : sum_sub[WORD_WIDTH-1:0];
   end
endmodule

/* hw/rtl/rme_mulseq.sv */
// modular multiply sequencer: add-and-double over all multiplier bits,
// one modular add per cycle on the shared adder; uses rme_pkg and rme_modadd
module rme_mulseq #(
   parameter int WORD_WIDTH = rme_pkg::WORD_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rme_pkg::mul_ctl_type     ctl,
   output rme_pkg::mul_stat_type    stat,
   input  logic [WORD_WIDTH-1:0]    acc_i,
   input  logic [WORD_WIDTH-1:0]    base_i,
   input  logic [WORD_WIDTH-1:0]    modulus_i,
   output logic [WORD_WIDTH-1:0]    product_o
);
   import rme_pkg::*;

   localparam int CNT_WIDTH = (WORD_WIDTH > 1) ? $clog2(WORD_WIDTH) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_ADD,
      ST_DBL
   } state_type;

   state_type              state_ff, state_in;
   logic [WORD_WIDTH-1:0]  x_ff, x_in;
   logic [WORD_WIDTH-1:0]  y_ff, y_in;
   logic [WORD_WIDTH-1:0]  acc_ff, acc_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [WORD_WIDTH-1:0]  op_a, op_b, add_sum;

   rme_modadd #(.WORD_WIDTH(WORD_WIDTH)) u_modadd (
      .a_i       (op_a),
      .b_i       (op_b),
      .modulus_i (modulus_i),
      .sum_o     (add_sum)
   );

   // operand select for the shared adder
   always_comb begin
      op_a = x_ff;
      op_b = '0;
      case (state_ff)
         ST_ADD: begin
            op_a = acc_ff;
            op_b = x_ff;
         end
         ST_DBL: begin
            op_b = x_ff;
         end
         default: begin
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      stat.done = 1'b0;
      stat.busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               x_in     = ctl.square ? base_i : acc_i;
               y_in     = base_i;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            // the running product can be an unreduced one when the modulus is one
            x_in     = add_sum;
            state_in = y_ff[0] ? ST_ADD : ST_DBL;
         end
         ST_ADD: begin
            acc_in   = add_sum;
            state_in = ST_DBL;
         end
         ST_DBL: begin
            x_in   = add_sum;
            y_in   = y_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(WORD_WIDTH - 1)) begin
               stat.done = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               state_in = y_ff[1] ? ST_ADD : ST_DBL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign product_o = acc_ff;

   a_add_then_dbl: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADD |=> state_ff == ST_DBL)
      else $error("accumulate step not followed by doubling");

   a_leave_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && $past(state_ff) == ST_IDLE) |-> $past(ctl.start))
      else $error("multiply began without a start");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> !stat.busy)
      else $error("sequencer still busy after done");
endmodule

/* hw/rtl/rsa_modular_exponentiation.sv */
// modular exponentiation, square-and-multiply with exponent lsb first
// flow, accept to response valid: an out-of-range message goes straight to finish, a zero exponent
// from check to finish, else per exponent bit up to the top set one: a check, a multiply when set,
// and except for the top set bit a square, led by a square start state when it follows a multiply
// throughput: one message at a time, a new one is taken once finish writes the response; finish
// waits while the response register is full; reset: synchronous, clears control state and both key registers
module rsa_modular_exponentiation #(
   parameter int WORD_WIDTH = rme_pkg::WORD_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   rme_req_if.sink                              req_bus,
   rme_rsp_if.source                            rsp_bus,
   input  logic                                 csr_wr_en,
   input  logic [rme_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [WORD_WIDTH-1:0]                csr_wr_data
);
   import rme_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WAIT_ACC,
      ST_SQR_START,
      ST_WAIT_SQR,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [WORD_WIDTH-1:0]  exponent_ff, exponent_in;
   logic [WORD_WIDTH-1:0]  modulus_ff, modulus_in;
   logic [WORD_WIDTH-1:0]  e_ff, e_in;
   logic [WORD_WIDTH-1:0]  base_ff, base_in;
   logic [WORD_WIDTH-1:0]  acc_ff, acc_in;
   logic                   oor_ff, oor_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0]  rsp_result_ff, rsp_result_in;
   logic                   rsp_oor_ff, rsp_oor_in;

   mul_ctl_type            mul_ctl;
   mul_stat_type           mul_stat;
   logic [WORD_WIDTH-1:0]  product;

   rme_mulseq #(.WORD_WIDTH(WORD_WIDTH)) u_mulseq (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mul_ctl),
      .stat      (mul_stat),
      .acc_i     (acc_ff),
      .base_i    (base_ff),
      .modulus_i (modulus_ff),
      .product_o (product)
   );

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result       = rsp_result_ff;
   assign rsp_bus.out_of_range = rsp_oor_ff;

   // key registers; the user must write them only while no transaction is in flight, the block does not enforce this
   always_comb begin
      exponent_in = exponent_ff;
      modulus_in  = modulus_ff;
      if (csr_wr_en) begin
         if (csr_index == CSR_EXPONENT) begin
            exponent_in = csr_wr_data;
         end else if (csr_index == CSR_MODULUS) begin
            modulus_in = csr_wr_data;
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      e_in           = e_ff;
      base_in        = base_ff;
      acc_in         = acc_ff;
      oor_in         = oor_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_result_in  = rsp_result_ff;
      rsp_oor_in     = rsp_oor_ff;
      mul_ctl.start  = 1'b0;
      mul_ctl.square = 1'b0;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               base_in = req_bus.message;
               e_in    = exponent_ff;
               oor_in  = (req_bus.message >= modulus_ff);
               if (req_bus.message >= modulus_ff) begin
                  acc_in   = req_bus.message;
                  state_in = ST_FINISH;
               end else begin
                  acc_in   = WORD_WIDTH'(1);
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (e_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               mul_ctl.start  = 1'b1;
               mul_ctl.square = !e_ff[0];
               state_in       = e_ff[0] ? ST_WAIT_ACC : ST_WAIT_SQR;
            end
         end
         ST_WAIT_ACC: begin
            if (mul_stat.done) begin
               acc_in = product;
               // no set bits left: the remaining squares are not needed
               if (e_ff[WORD_WIDTH-1:1] == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SQR_START;
               end
            end
         end
         ST_SQR_START: begin
            mul_ctl.start  = 1'b1;
            mul_ctl.square = 1'b1;
            state_in       = ST_WAIT_SQR;
         end
         ST_WAIT_SQR: begin
            if (mul_stat.done) begin
               base_in  = product;
               e_in     = e_ff >> 1;
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = acc_ff;
               rsp_oor_in    = oor_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         exponent_ff  <= '0;
         modulus_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         exponent_ff  <= exponent_in;
         modulus_ff   <= modulus_in;
      end
      e_ff          <= e_in;
      base_ff       <= base_in;
      acc_ff        <= acc_in;
      oor_ff        <= oor_in;
      rsp_result_ff <= rsp_result_in;
      rsp_oor_ff    <= rsp_oor_in;
   end

   a_done_while_waiting: assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |-> (state_ff == ST_WAIT_ACC || state_ff == ST_WAIT_SQR))
      else $error("multiply finished outside a wait state");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      mul_ctl.start |-> !mul_stat.busy)
      else $error("multiply started while sequencer busy");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while a message is in work");

   a_no_work_on_error: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK || state_ff == ST_WAIT_ACC || state_ff == ST_WAIT_SQR) |-> !oor_ff)
      else $error("out-of-range message entered the exponent loop");
endmodule
